[src/fdem_pkg.sv]
// shared constants for the forward-difference edge map core
package fdem_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 8;

	localparam int NCOMP        = 3;
	localparam int ROW_BITS     = 12;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_WIDTH_BITS  = 11;
	localparam int CFG_HEIGHT_BITS = 13;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_MODE     = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_SELECT = 2'd3;

	localparam logic [CFG_WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
	localparam logic [CFG_HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 13'd1024;

	localparam logic [1:0] CHAN_ALL = 2'd3;

endpackage

[src/forward_difference_edge_map_core.sv]
// top level of the forward-difference edge map core with its line buffer
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tdata: comp0, comp1, comp2
//  m_      | out       | m_tvalid / m_tready  | m_tdata: row, col, c0, c1, c2; m_tlast: done
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle while the output takes results; an item of the last row of an
// image taller than one row gives two results through the single output register and
// so holds the input back until the second result has been loaded.
// the line buffer has one read and one write per item: the column ahead is
// read when an item is taken, the column itself comes from the previous read.
// after reset and after every configuration write the line buffer is re-read
// at the coming column before the next item is taken.
// reset clears counters and handshake state and loads the default configuration; no clearing pass.
module forward_difference_edge_map_core
	import fdem_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// comp0_in, comp1_in, comp2_in from bit 0 up, zero padded to bytes
	input  logic [((NCOMP*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// out_row, out_col, out_c0, out_c1, out_c2 from bit 0 up, zero padded to bytes
	output logic [((ROW_BITS+$clog2(MAX_WIDTH)+NCOMP*(SAMPLE_BITS+1)+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int SB       = SAMPLE_BITS;
	localparam int RB       = SAMPLE_BITS + 1;
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int WE_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int CMP      = (WE_BITS > CFG_WIDTH_BITS) ? WE_BITS : CFG_WIDTH_BITS;
	localparam int HB       = CFG_HEIGHT_BITS;
	localparam int PIX      = NCOMP * SB;
	localparam int OUT_DATA = ROW_BITS + CW + NCOMP * RB;
	localparam int OUT_W    = ((OUT_DATA + 7) / 8) * 8;

	// configuration
	logic [CFG_WIDTH_BITS-1:0]  width_q;
	logic [CFG_HEIGHT_BITS-1:0] height_q;
	logic                       color_q;
	logic [1:0]                 chan_q;
	logic                       cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			color_q  <= 1'b0;
			chan_q   <= CHAN_ALL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:    width_q  <= cfg_data[CFG_WIDTH_BITS-1:0];
				CFG_IMAGE_HEIGHT:   height_q <= cfg_data[CFG_HEIGHT_BITS-1:0];
				CFG_COLOR_MODE:     color_q  <= cfg_data[0];
				CFG_CHANNEL_SELECT: chan_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// effective size and current position
	logic [CMP-1:0]      width_ext, w_eff;
	logic [HB-1:0]       h_eff;
	logic [CW-1:0]       col_q, cc;
	logic [ROW_BITS-1:0] row_q, rr;
	logic                last_col, last_row;

	always_comb begin
		width_ext = CMP'(width_q);
		if (width_ext == '0) begin
			w_eff = CMP'(1);
		end else if (width_ext > CMP'(MAX_WIDTH)) begin
			w_eff = CMP'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
		if (height_q == '0) begin
			h_eff = HB'(1);
		end else if (height_q > HB'(HEIGHT_LIMIT)) begin
			h_eff = HB'(HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
		cc       = (CMP'(col_q) >= w_eff) ? CW'(w_eff - CMP'(1)) : col_q;
		rr       = (HB'(row_q) >= h_eff) ? ROW_BITS'(h_eff - HB'(1)) : row_q;
		last_col = (CMP'(cc) == w_eff - CMP'(1));
		last_row = (HB'(rr) == h_eff - HB'(1));
	end

	// handshake control
	logic pf_ok_q, prime, accept;
	logic s1_valid_q, a_sent_q, fwd_s1;
	logic pend_a, pend_b, out_free, out_load, s1_fin;
	logic out_valid_q;

	logic [SB-1:0]       cur_s1   [NCOMP];
	logic [SB-1:0]       above_s1 [NCOMP];
	logic [ROW_BITS-1:0] row_s1;
	logic [CW-1:0]       col_s1;
	logic                last_col_s1, last_row_s1, has_a_s1;

	assign pend_a   = has_a_s1 && !a_sent_q;
	assign pend_b   = last_row_s1;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = s1_valid_q && out_free && (pend_a || pend_b);
	assign s1_fin   = s1_valid_q && (!(pend_a || pend_b) || (out_free && !(pend_a && pend_b)));
	assign s_tready = pf_ok_q && (!s1_valid_q || s1_fin);
	assign accept   = s_tvalid && s_tready;
	assign prime    = !pf_ok_q && !s1_valid_q && !cfg_we;

	// line buffer
	logic [CW-1:0]  rd_addr;
	logic [PIX-1:0] rd_data;

	assign rd_addr = prime ? cc : (last_col ? '0 : cc + CW'(1));

	fdem_ram #(
		.WIDTH(PIX),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(cc),
		.wr_data(s_tdata[PIX-1:0]),
		.rd_en  (accept || prime),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_ok_q    <= 1'b0;
			s1_valid_q <= 1'b0;
			a_sent_q   <= 1'b0;
			fwd_s1     <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (cfg_we) begin
				pf_ok_q <= 1'b0;
			end else if (prime) begin
				pf_ok_q <= 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fin) begin
				s1_valid_q <= 1'b0;
			end
			if (accept || s1_fin) begin
				a_sent_q <= 1'b0;
			end else if (out_load && pend_a && pend_b) begin
				a_sent_q <= 1'b1;
			end
			if (prime) begin
				fwd_s1 <= 1'b0;
			end else if (accept) begin
				fwd_s1 <= last_col && (cc == '0);
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : rr + ROW_BITS'(1);
				end else begin
					col_q <= cc + CW'(1);
					row_q <= rr;
				end
			end
		end
	end

	// item register
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < NCOMP; k++) begin
				cur_s1[k]   <= s_tdata[k*SB +: SB];
				above_s1[k] <= fwd_s1 ? cur_s1[k] : rd_data[k*SB +: SB];
			end
			row_s1      <= rr;
			col_s1      <= cc;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			has_a_s1    <= (rr != '0);
		end
	end

	// gradient and pass-through selection
	logic [RB-1:0] res [NCOMP];

	always_comb begin
		logic          proc;
		logic [SB-1:0] dv, dh, right;
		for (int k = 0; k < NCOMP; k++) begin
			proc  = color_q ? ((chan_q == CHAN_ALL) || (chan_q == 2'(k))) : (k == 0);
			right = rd_data[k*SB +: SB];
			dv    = (cur_s1[k] > above_s1[k]) ? cur_s1[k] - above_s1[k]
			                                 : above_s1[k] - cur_s1[k];
			dh    = (right > above_s1[k]) ? right - above_s1[k] : above_s1[k] - right;
			if (!pend_a) begin
				res[k] = RB'(cur_s1[k]);
			end else if (!last_col_s1 && proc) begin
				res[k] = RB'(dv) + RB'(dh);
			end else begin
				res[k] = RB'(above_s1[k]);
			end
			if (!color_q && (k != 0)) begin
				res[k] = '0;
			end
		end
	end

	// result register
	logic [ROW_BITS-1:0] out_row_q;
	logic [CW-1:0]       out_col_q;
	logic [RB-1:0]       out_c_q [NCOMP];
	logic                out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= pend_a ? row_s1 - ROW_BITS'(1) : row_s1;
			out_col_q  <= col_s1;
			out_done_q <= !pend_a && last_col_s1;
			for (int k = 0; k < NCOMP; k++) begin
				out_c_q[k] <= res[k];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = OUT_W'({out_c_q[2], out_c_q[1], out_c_q[0], out_col_q, out_row_q});

	// checks
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col && last_row |=> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap at end of image");

	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		a_sent_q |-> s1_valid_q && last_row_s1 && has_a_s1)
		else $error("second result pending without a last-row item");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 && s1_valid_q |-> last_col_s1 && (col_s1 == '0))
		else $error("line buffer bypass outside single-column image");

	a_prime: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("item taken before line buffer re-read");

endmodule

[src/fdem_ram.sv]
// generic single-port-write, registered-read ram
module fdem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
